>>> rtl/srsw_pkg.sv
package srsw_pkg;

   // Defaults for the top-level parameters
   localparam int WINDOW_SIZE_DEF = 6;
   localparam int SEQ_SPACE_DEF   = 12;

   // Message framing
   localparam int MSG_BYTES   = 20;
   localparam int LO_W        = 64;
   localparam int MID_W       = 64;
   localparam int HI_W        = 32;
   localparam int GROUP_BYTES = 5;
   localparam int GROUPS      = MSG_BYTES / GROUP_BYTES;
   localparam int GROUP_SUM_W = 11;
   localparam int CHECK_W     = 13;
   localparam int RX_W        = 16;
   localparam int ACK_UNUSED  = -1;

   // Widest sequence number over the parameter range, and the sent width
   localparam int MAX_SEQ_W = 6;
   localparam int TX_SEQ_W  = 4;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   // Input function codes
   localparam logic [1:0] FUNC_NEW     = 2'd0;
   localparam logic [1:0] FUNC_ACK     = 2'd1;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
   localparam logic [1:0] FUNC_NONE    = 2'd3;

   typedef enum logic [2:0] {
      ACT_SENT          = 3'd0,
      ACT_RESENT        = 3'd1,
      ACT_DROPPED       = 3'd2,
      ACT_CORRUPT       = 3'd3,
      ACT_OUT_OF_WINDOW = 3'd4,
      ACT_DUPLICATE     = 3'd5,
      ACT_ACCEPTED      = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      TIMER_NONE    = 2'd0,
      TIMER_START   = 2'd1,
      TIMER_STOP    = 2'd2,
      TIMER_RESTART = 2'd3
   } timer_type;

   typedef enum logic [1:0] {
      CMD_NEW,
      CMD_ACK,
      CMD_TIMEOUT
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SLIDE,
      BACK_RESEND
   } back_state_type;

   // Classified event handed from front to back
   typedef struct packed {
      cmd_kind_type                kind;
      logic [LO_W-1:0]             payload_lo;
      logic [MID_W-1:0]            payload_mid;
      logic [HI_W-1:0]             payload_hi;
      logic signed [CHECK_W-1:0]   byte_sum;
      logic                        chk_ok;
      logic                        in_range;
      logic [MAX_SEQ_W-1:0]        ack_seq;
   } cmd_type;

endpackage

>>> rtl/srsw_front.sv
module srsw_front
   import srsw_pkg::*;
#(
   parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [LO_W-1:0]        req_payload_lo,
   input  logic [MID_W-1:0]       req_payload_mid,
   input  logic [HI_W-1:0]        req_payload_hi,
   input  logic signed [RX_W-1:0] req_rx_seq,
   input  logic signed [RX_W-1:0] req_rx_ack,
   input  logic signed [RX_W-1:0] req_rx_check,
   output logic                   push_valid,
   output cmd_type                push_data,
   input  logic                   push_ready
);

   localparam int HDR_W = RX_W + 1;
   localparam int SUM_W = RX_W + 2;

   function automatic logic signed [GROUP_SUM_W-1:0] group_sum(
      input logic [GROUP_BYTES*8-1:0] grp
   );
      logic signed [GROUP_SUM_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < GROUP_BYTES; i++) begin
         acc = acc + GROUP_SUM_W'(signed'(grp[8*i +: 8]));
      end
      return acc;
   endfunction

   logic [MSG_BYTES*8-1:0]        msg;
   logic                          take;

   logic                          stage_valid_ff, stage_valid_in;
   cmd_kind_type                  kind_ff, kind_in;
   logic [LO_W-1:0]               lo_ff;
   logic [MID_W-1:0]              mid_ff;
   logic [HI_W-1:0]               hi_ff;
   logic signed [GROUP_SUM_W-1:0] group_ff [GROUPS];
   logic signed [HDR_W-1:0]       hdr_ff;
   logic signed [RX_W-1:0]        check_ff;
   logic                          in_range_ff, in_range_in;
   logic [MAX_SEQ_W-1:0]          ack_ff;

   logic signed [CHECK_W-1:0]     byte_sum;
   logic signed [SUM_W-1:0]       rx_sum;

   assign msg       = {req_payload_hi, req_payload_mid, req_payload_lo};
   assign req_ready = !stage_valid_ff || push_ready;
   assign take      = req_valid && req_ready;

   // Classify the beat and range-check the acknowledged number
   always_comb begin
      case (req_func)
         FUNC_NEW:     kind_in = CMD_NEW;
         FUNC_ACK:     kind_in = CMD_ACK;
         default:      kind_in = CMD_TIMEOUT;
      endcase
      in_range_in = !req_rx_ack[RX_W-1] &&
                    (req_rx_ack[RX_W-2:0] < (RX_W-1)'(SEQ_SPACE));
      stage_valid_in = stage_valid_ff;
      if (push_valid && push_ready) begin
         stage_valid_in = 1'b0;
      end
      // drop the unused function code here
      if (take && req_func != FUNC_NONE) begin
         stage_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Hold the beat with its partial byte sums
   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff     <= kind_in;
         lo_ff       <= req_payload_lo;
         mid_ff      <= req_payload_mid;
         hi_ff       <= req_payload_hi;
         hdr_ff      <= HDR_W'(req_rx_seq) + HDR_W'(req_rx_ack);
         check_ff    <= req_rx_check;
         in_range_ff <= in_range_in;
         ack_ff      <= req_rx_ack[MAX_SEQ_W-1:0];
         for (int g = 0; g < GROUPS; g++) begin
            group_ff[g] <= group_sum(msg[g*GROUP_BYTES*8 +: GROUP_BYTES*8]);
         end
      end
   end

   // Finish the checksum and build the command
   always_comb begin
      byte_sum = '0;
      for (int g = 0; g < GROUPS; g++) begin
         byte_sum = byte_sum + CHECK_W'(group_ff[g]);
      end
      rx_sum = SUM_W'(hdr_ff) + SUM_W'(byte_sum);

      push_data.kind        = kind_ff;
      push_data.payload_lo  = lo_ff;
      push_data.payload_mid = mid_ff;
      push_data.payload_hi  = hi_ff;
      push_data.byte_sum    = byte_sum;
      push_data.chk_ok      = (rx_sum == SUM_W'(check_ff));
      push_data.in_range    = in_range_ff;
      push_data.ack_seq     = ack_ff;
   end

   assign push_valid = stage_valid_ff;

endmodule

>>> rtl/srsw_queue.sv
module srsw_queue
   import srsw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_data,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_data,
   input  logic    pop_ready
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/srsw_back.sv
module srsw_back
   import srsw_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
   parameter int SEQ_SPACE   = SEQ_SPACE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  cmd_type                   cmd_data,
   output logic                      cmd_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_action,
   output logic [1:0]                rsp_timer_cmd,
   output logic [TX_SEQ_W-1:0]       rsp_tx_seq,
   output logic signed [CHECK_W-1:0] rsp_tx_check,
   output logic [LO_W-1:0]           rsp_tx_payload_lo,
   output logic [MID_W-1:0]          rsp_tx_payload_mid,
   output logic [HI_W-1:0]           rsp_tx_payload_hi
);

   localparam int SEQ_W     = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
   localparam int LIMIT_INT = (WINDOW_SIZE < SEQ_SPACE - 1) ? WINDOW_SIZE : SEQ_SPACE - 1;
   localparam logic [SEQ_W-1:0] LAST_SEQ = SEQ_W'(SEQ_SPACE - 1);
   localparam logic [SEQ_W-1:0] LIMIT    = SEQ_W'(LIMIT_INT);
   localparam int ROW_W = CHECK_W + HI_W + MID_W + LO_W;

   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
      return (s == LAST_SEQ) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [SEQ_W-1:0] seq_dist(
      input logic [SEQ_W-1:0] a,
      input logic [SEQ_W-1:0] b
   );
      logic [SEQ_W:0] diff;
      diff = {1'b0, a} - {1'b0, b};
      if (a < b) begin
         diff = diff + (SEQ_W+1)'(SEQ_SPACE);
      end
      return diff[SEQ_W-1:0];
   endfunction

   function automatic logic signed [CHECK_W-1:0] frame_check(
      input logic [SEQ_W-1:0]        s,
      input logic signed [CHECK_W-1:0] sum
   );
      return CHECK_W'(sum + CHECK_W'(s) + CHECK_W'(ACK_UNUSED));
   endfunction

   back_state_type            state_ff, state_in;
   logic [SEQ_W-1:0]          base_ff, base_in;
   logic [SEQ_W-1:0]          next_ff, next_in;
   logic [SEQ_SPACE-1:0]      marks_ff, marks_in;
   logic                      was_base_ff, was_base_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   action_type                action_ff, action_in;
   timer_type                 timer_ff, timer_in;
   logic [TX_SEQ_W-1:0]       tx_seq_ff, tx_seq_in;
   logic signed [CHECK_W-1:0] tx_check_ff, tx_check_in;
   logic [LO_W-1:0]           tx_lo_ff, tx_lo_in;
   logic [MID_W-1:0]          tx_mid_ff, tx_mid_in;
   logic [HI_W-1:0]           tx_hi_ff, tx_hi_in;
   logic                      load_rsp;

   logic [ROW_W-1:0]          store_mem [SEQ_SPACE];
   logic [ROW_W-1:0]          rd_row_ff;
   logic [ROW_W-1:0]          wr_row;
   logic                      mem_we;

   logic [SEQ_W-1:0]          outstanding;
   logic [SEQ_W-1:0]          ack;
   logic                      out_free;
   logic signed [CHECK_W-1:0] rd_sum;

   assign outstanding = seq_dist(next_ff, base_ff);
   assign ack         = cmd_data.ack_seq[SEQ_W-1:0];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign wr_row      = {cmd_data.byte_sum, cmd_data.payload_hi,
                         cmd_data.payload_mid, cmd_data.payload_lo};
   assign rd_sum      = rd_row_ff[ROW_W-1 -: CHECK_W];

   // Sequencer: execute one command, then slide or resend as needed
   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      next_in     = next_ff;
      marks_in    = marks_ff;
      was_base_in = was_base_ff;
      cmd_ready   = 1'b0;
      mem_we      = 1'b0;
      load_rsp    = 1'b0;
      action_in   = action_ff;
      timer_in    = TIMER_NONE;
      tx_seq_in   = '0;
      tx_check_in = '0;
      tx_lo_in    = '0;
      tx_mid_in   = '0;
      tx_hi_in    = '0;

      case (state_ff)
         BACK_IDLE: begin
            // take a command only when the result register can receive it
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               case (cmd_data.kind)
                  CMD_NEW: begin
                     load_rsp = 1'b1;
                     if (outstanding >= LIMIT) begin
                        action_in = ACT_DROPPED;
                     end else begin
                        mem_we      = 1'b1;
                        action_in   = ACT_SENT;
                        timer_in    = (outstanding == '0) ? TIMER_START : TIMER_NONE;
                        tx_seq_in   = TX_SEQ_W'(next_ff);
                        tx_check_in = frame_check(next_ff, cmd_data.byte_sum);
                        tx_lo_in    = cmd_data.payload_lo;
                        tx_mid_in   = cmd_data.payload_mid;
                        tx_hi_in    = cmd_data.payload_hi;
                        next_in     = seq_inc(next_ff);
                     end
                  end
                  CMD_ACK: begin
                     if (!cmd_data.chk_ok) begin
                        load_rsp  = 1'b1;
                        action_in = ACT_CORRUPT;
                     end else if (!cmd_data.in_range ||
                                  seq_dist(ack, base_ff) >= outstanding) begin
                        load_rsp  = 1'b1;
                        action_in = ACT_OUT_OF_WINDOW;
                     end else if (marks_ff[ack]) begin
                        load_rsp  = 1'b1;
                        action_in = ACT_DUPLICATE;
                     end else begin
                        marks_in[ack] = 1'b1;
                        was_base_in   = (ack == base_ff);
                        state_in      = BACK_SLIDE;
                     end
                  end
                  default: begin
                     state_in = BACK_RESEND;
                  end
               endcase
            end
         end
         BACK_SLIDE: begin
            // advance the base past one acknowledged entry per cycle
            if (base_ff != next_ff && marks_ff[base_ff]) begin
               marks_in[base_ff] = 1'b0;
               base_in           = seq_inc(base_ff);
            end else begin
               load_rsp  = 1'b1;
               action_in = ACT_ACCEPTED;
               if (was_base_ff) begin
                  timer_in = (base_ff != next_ff) ? TIMER_RESTART : TIMER_STOP;
               end
               state_in = BACK_IDLE;
            end
         end
         BACK_RESEND: begin
            load_rsp    = 1'b1;
            action_in   = ACT_RESENT;
            timer_in    = (outstanding != '0) ? TIMER_START : TIMER_NONE;
            tx_seq_in   = TX_SEQ_W'(base_ff);
            tx_check_in = frame_check(base_ff, rd_sum);
            tx_lo_in    = rd_row_ff[LO_W-1:0];
            tx_mid_in   = rd_row_ff[LO_W +: MID_W];
            tx_hi_in    = rd_row_ff[LO_W+MID_W +: HI_W];
            state_in    = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         base_ff      <= '0;
         next_ff      <= '0;
         marks_ff     <= '0;
         was_base_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         marks_ff     <= marks_in;
         was_base_ff  <= was_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result beat until it is taken
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         action_ff   <= action_in;
         timer_ff    <= timer_in;
         tx_seq_ff   <= tx_seq_in;
         tx_check_ff <= tx_check_in;
         tx_lo_ff    <= tx_lo_in;
         tx_mid_ff   <= tx_mid_in;
         tx_hi_ff    <= tx_hi_in;
      end
   end

   // Payload store: write at the next sequence, read at the base
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[next_ff] <= wr_row;
      end
      rd_row_ff <= store_mem[base_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = action_ff;
   assign rsp_timer_cmd      = timer_ff;
   assign rsp_tx_seq         = tx_seq_ff;
   assign rsp_tx_check       = tx_check_ff;
   assign rsp_tx_payload_lo  = tx_lo_ff;
   assign rsp_tx_payload_mid = tx_mid_ff;
   assign rsp_tx_payload_hi  = tx_hi_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) outstanding <= LIMIT)
      else $error("outstanding count exceeds window limit");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != BACK_IDLE |-> !rsp_valid_ff)
      else $error("result register busy during slide or resend");
   assert property (@(posedge clock) disable iff (reset) !marks_ff[next_ff])
      else $error("ack mark set outside the window");
`endif

endmodule

>>> rtl/selective_repeat_sender_window_unit.sv
// Selective-repeat ARQ sender window. Each request beat is a new 20-byte
// message, an incoming ACK packet or a timer expiry; each yields one
// response beat with an action code, a timer command and, for sent or resent
// packets, the framed packet (unused function code 3 is taken and dropped).
// A front stage registers the beat with partial byte sums and finishes the
// checksum; a two-entry queue then feeds the back end, which owns the window
// state, ack marks and a payload store with registered reads. A new message
// or a rejected ACK is answered from the idle state; a timeout passes
// through the resend state for the store read, and an accepted ACK through
// the slide state, which moves the base past one acknowledged entry at a
// time. The back end handles one event at a time and takes no new one while
// it is in the slide or resend state; the front keeps taking beats while the
// queue has room and while a response waits to be taken.
module selective_repeat_sender_window_unit
   import srsw_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
   parameter int SEQ_SPACE   = SEQ_SPACE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_func,
   input  logic [LO_W-1:0]           req_payload_lo,
   input  logic [MID_W-1:0]          req_payload_mid,
   input  logic [HI_W-1:0]           req_payload_hi,
   input  logic signed [RX_W-1:0]    req_rx_seq,
   input  logic signed [RX_W-1:0]    req_rx_ack,
   input  logic signed [RX_W-1:0]    req_rx_check,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_action,
   output logic [1:0]                rsp_timer_cmd,
   output logic [TX_SEQ_W-1:0]       rsp_tx_seq,
   output logic signed [CHECK_W-1:0] rsp_tx_check,
   output logic [LO_W-1:0]           rsp_tx_payload_lo,
   output logic [MID_W-1:0]          rsp_tx_payload_mid,
   output logic [HI_W-1:0]           rsp_tx_payload_hi
);

   logic    push_valid, push_ready;
   cmd_type push_data;
   logic    pop_valid, pop_ready;
   cmd_type pop_data;

   srsw_front #(
      .SEQ_SPACE (SEQ_SPACE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_payload_lo  (req_payload_lo),
      .req_payload_mid (req_payload_mid),
      .req_payload_hi  (req_payload_hi),
      .req_rx_seq      (req_rx_seq),
      .req_rx_ack      (req_rx_ack),
      .req_rx_check    (req_rx_check),
      .push_valid      (push_valid),
      .push_data       (push_data),
      .push_ready      (push_ready)
   );

   srsw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   srsw_back #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .SEQ_SPACE   (SEQ_SPACE)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (pop_valid),
      .cmd_data           (pop_data),
      .cmd_ready          (pop_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_action         (rsp_action),
      .rsp_timer_cmd      (rsp_timer_cmd),
      .rsp_tx_seq         (rsp_tx_seq),
      .rsp_tx_check       (rsp_tx_check),
      .rsp_tx_payload_lo  (rsp_tx_payload_lo),
      .rsp_tx_payload_mid (rsp_tx_payload_mid),
      .rsp_tx_payload_hi  (rsp_tx_payload_hi)
   );

endmodule

>>> bench/selective_repeat_sender_window_unit_test.sv
`timescale 1ns / 100ps

module selective_repeat_sender_window_unit_test;
   import srsw_pkg::*;

   localparam int SEQ_SPACE    = SEQ_SPACE_DEF;
   localparam int WINDOW_LIMIT = (WINDOW_SIZE_DEF < SEQ_SPACE_DEF - 1) ?
                                 WINDOW_SIZE_DEF : SEQ_SPACE_DEF - 1;
   localparam int EVENT_COUNT  = 1750;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 600;
   localparam int DRAIN_CYCLES = 20;

   // Two copies of the window state: one steers stimulus, one checks
   localparam int GEN_VIEW = 0;
   localparam int CHK_VIEW = 1;

   typedef struct packed {
      logic [1:0]         func;
      logic [LO_W-1:0]    lo;
      logic [MID_W-1:0]   mid;
      logic [HI_W-1:0]    hi;
      logic [RX_W-1:0]    rx_seq;
      logic [RX_W-1:0]    rx_ack;
      logic [RX_W-1:0]    rx_check;
   } req_item_type;

   typedef struct packed {
      action_type         action;
      timer_type          timer;
      logic [TX_SEQ_W-1:0] seq;
      logic [CHECK_W-1:0] check;
      logic [LO_W-1:0]    lo;
      logic [MID_W-1:0]   mid;
      logic [HI_W-1:0]    hi;
   } rsp_exp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_func = FUNC_NEW;
   logic [LO_W-1:0]           req_payload_lo = '0;
   logic [MID_W-1:0]          req_payload_mid = '0;
   logic [HI_W-1:0]           req_payload_hi = '0;
   logic signed [RX_W-1:0]    req_rx_seq = '0;
   logic signed [RX_W-1:0]    req_rx_ack = '0;
   logic signed [RX_W-1:0]    req_rx_check = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [2:0]                rsp_action;
   logic [1:0]                rsp_timer_cmd;
   logic [TX_SEQ_W-1:0]       rsp_tx_seq;
   logic signed [CHECK_W-1:0] rsp_tx_check;
   logic [LO_W-1:0]           rsp_tx_payload_lo;
   logic [MID_W-1:0]          rsp_tx_payload_mid;
   logic [HI_W-1:0]           rsp_tx_payload_hi;

   selective_repeat_sender_window_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_payload_lo     (req_payload_lo),
      .req_payload_mid    (req_payload_mid),
      .req_payload_hi     (req_payload_hi),
      .req_rx_seq         (req_rx_seq),
      .req_rx_ack         (req_rx_ack),
      .req_rx_check       (req_rx_check),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_action         (rsp_action),
      .rsp_timer_cmd      (rsp_timer_cmd),
      .rsp_tx_seq         (rsp_tx_seq),
      .rsp_tx_check       (rsp_tx_check),
      .rsp_tx_payload_lo  (rsp_tx_payload_lo),
      .rsp_tx_payload_mid (rsp_tx_payload_mid),
      .rsp_tx_payload_hi  (rsp_tx_payload_hi)
   );

   always #10 clock = ~clock;

   // Window state, per view
   int         win_base [2];
   int         win_next [2];
   bit         acked    [2][SEQ_SPACE];
   logic [63:0] keep_lo  [2][SEQ_SPACE];
   logic [63:0] keep_mid [2][SEQ_SPACE];
   logic [31:0] keep_hi  [2][SEQ_SPACE];
   bit         sent_once [SEQ_SPACE];

   req_item_type queued_events [$];
   rsp_exp_type  due_responses [$];
   int        errors = 0;

   // Sum of the 20 payload bytes, each taken as signed
   function automatic int byte_sum(input logic [63:0] lo, input logic [63:0] mid,
                                   input logic [31:0] hi);
      logic [159:0] all;
      int acc;
      int b;
      all = {hi, mid, lo};
      acc = 0;
      for (int i = 0; i < MSG_BYTES; i++) begin
         b = all[8*i +: 8];
         if (b >= 128) b -= 256;
         acc += b;
      end
      return acc;
   endfunction

   // Frame the stored packet at a sequence number
   function automatic rsp_exp_type framed_packet(input int v, input int s);
      rsp_exp_type r;
      int sum;
      r = '0;
      r.seq = s[TX_SEQ_W-1:0];
      r.lo  = keep_lo[v][s];
      r.mid = keep_mid[v][s];
      r.hi  = keep_hi[v][s];
      sum = s + ACK_UNUSED + byte_sum(r.lo, r.mid, r.hi);
      r.check = sum[CHECK_W-1:0];
      return r;
   endfunction

   // Apply one event to a view of the window and return its response
   function automatic rsp_exp_type window_outcome(input int v, input req_item_type ev);
      rsp_exp_type r;
      int outstanding;
      int ack;
      int sq;
      int chk;
      int sum;
      logic signed [RX_W-1:0] s16;
      bit was_base;
      r = '0;
      outstanding = (win_next[v] + SEQ_SPACE - win_base[v]) % SEQ_SPACE;
      case (ev.func)
         FUNC_NEW: begin
            if (outstanding >= WINDOW_LIMIT) begin
               r.action = ACT_DROPPED;
            end else begin
               keep_lo[v][win_next[v]]  = ev.lo;
               keep_mid[v][win_next[v]] = ev.mid;
               keep_hi[v][win_next[v]]  = ev.hi;
               r = framed_packet(v, win_next[v]);
               r.action = ACT_SENT;
               r.timer = (outstanding == 0) ? TIMER_START : TIMER_NONE;
               win_next[v] = (win_next[v] + 1) % SEQ_SPACE;
            end
         end
         FUNC_TIMEOUT: begin
            r = framed_packet(v, win_base[v]);
            r.action = ACT_RESENT;
            r.timer = (outstanding != 0) ? TIMER_START : TIMER_NONE;
         end
         default: begin
            s16 = ev.rx_ack;   ack = s16;
            s16 = ev.rx_seq;   sq  = s16;
            s16 = ev.rx_check; chk = s16;
            sum = sq + ack + byte_sum(ev.lo, ev.mid, ev.hi);
            if (sum != chk) begin
               r.action = ACT_CORRUPT;
            end else if (ack < 0 || ack >= SEQ_SPACE ||
                         (ack + SEQ_SPACE - win_base[v]) % SEQ_SPACE >= outstanding) begin
               r.action = ACT_OUT_OF_WINDOW;
            end else if (acked[v][ack]) begin
               r.action = ACT_DUPLICATE;
            end else begin
               acked[v][ack] = 1'b1;
               was_base = (ack == win_base[v]);
               // slide the base past every acknowledged entry
               while (win_base[v] != win_next[v] && acked[v][win_base[v]]) begin
                  acked[v][win_base[v]] = 1'b0;
                  win_base[v] = (win_base[v] + 1) % SEQ_SPACE;
               end
               r.action = ACT_ACCEPTED;
               if (was_base)
                  r.timer = (win_base[v] != win_next[v]) ? TIMER_RESTART : TIMER_STOP;
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 19))
         0:       return 64'h8080_8080_8080_8080;
         1:       return 64'h7F7F_7F7F_7F7F_7F7F;
         2:       return '1;
         3:       return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_item_type new_message(input logic [63:0] lo,
                                                input logic [63:0] mid,
                                                input logic [31:0] hi);
      req_item_type it;
      it = '0;
      it.func = FUNC_NEW;
      it.lo = lo;
      it.mid = mid;
      it.hi = hi;
      it.rx_seq = RX_W'($urandom);
      it.rx_ack = RX_W'($urandom);
      it.rx_check = RX_W'($urandom);
      return it;
   endfunction

   // ACK packet with a consistent checksum, or one bit off when corrupt
   function automatic req_item_type make_ack(input int ack, input bit corrupt);
      req_item_type it;
      logic signed [RX_W-1:0] s16;
      int bs;
      int sq;
      int sum;
      it = '0;
      it.func = FUNC_ACK;
      it.lo = rand_word();
      it.mid = rand_word();
      it.hi = HI_W'(rand_word());
      bs = byte_sum(it.lo, it.mid, it.hi);
      s16 = RX_W'($urandom);
      sq = s16;
      sum = sq + ack + bs;
      if (sum > 32767 || sum < -32768) begin
         sq = -(ack + bs);
         if (sq > 32767) sq = 32767;
         if (sq < -32768) sq = -32768;
         sum = sq + ack + bs;
      end
      it.rx_ack = ack[RX_W-1:0];
      it.rx_seq = sq[RX_W-1:0];
      it.rx_check = sum[RX_W-1:0];
      if (corrupt) it.rx_check = it.rx_check ^ (16'd1 << $urandom_range(0, RX_W-1));
      return it;
   endfunction

   function automatic req_item_type timer_expiry();
      req_item_type it;
      it = new_message({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      it.func = FUNC_TIMEOUT;
      return it;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic queue_event(input req_item_type it);
      rsp_exp_type r;
      queued_events.push_back(it);
      if (it.func != FUNC_NONE) begin
         r = window_outcome(GEN_VIEW, it);
         if (r.action == ACT_SENT) sent_once[r.seq] = 1'b1;
      end
   endtask

   // Stimulus: directed opening, then random traffic steered by the window view
   initial begin
      int made;
      int pick;
      int outstanding;
      req_item_type it;

      for (int i = 0; i < SEQ_SPACE; i++) begin
         acked[GEN_VIEW][i] = 1'b0;
         acked[CHK_VIEW][i] = 1'b0;
         sent_once[i] = 1'b0;
      end
      win_base = '{0, 0};
      win_next = '{0, 0};

      // fill the window with extreme payloads, then overflow it
      queue_event(new_message('0, '0, '0));
      queue_event(new_message('1, '1, '1));
      queue_event(new_message(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, 32'h8080_8080));
      queue_event(new_message(64'h7F7F_7F7F_7F7F_7F7F, 64'h7F7F_7F7F_7F7F_7F7F, 32'h7F7F_7F7F));
      queue_event(new_message({$urandom, $urandom}, {$urandom, $urandom}, $urandom));
      queue_event(new_message({$urandom, $urandom}, {$urandom, $urandom}, $urandom));
      queue_event(new_message({$urandom, $urandom}, {$urandom, $urandom}, $urandom));
      queue_event(timer_expiry());
      // rejected ACKs: bad checksum, then outside the window
      queue_event(make_ack(0, 1'b1));
      queue_event(make_ack(-1, 1'b0));
      queue_event(make_ack(SEQ_SPACE, 1'b0));
      queue_event(make_ack(32767, 1'b0));
      queue_event(make_ack(-32768, 1'b0));
      queue_event(make_ack(WINDOW_LIMIT, 1'b0));
      // ACK past the base, repeat it, then slide the base step by step
      queue_event(make_ack(2, 1'b0));
      queue_event(make_ack(2, 1'b0));
      queue_event(make_ack(0, 1'b0));
      queue_event(make_ack(1, 1'b0));
      queue_event(make_ack(5, 1'b0));
      queue_event(make_ack(4, 1'b0));
      queue_event(make_ack(3, 1'b0));
      it = timer_expiry();
      it.func = FUNC_NONE;
      queue_event(it);
      made = 21;

      // random traffic, mostly well-formed window activity
      while (made < EVENT_COUNT) begin
         outstanding = (win_next[GEN_VIEW] + SEQ_SPACE - win_base[GEN_VIEW]) % SEQ_SPACE;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            it = new_message(rand_word(), rand_word(), HI_W'(rand_word()));
         end else if (pick < 75) begin
            if (outstanding > 0)
               it = make_ack((win_base[GEN_VIEW] + $urandom_range(0, outstanding - 1))
                             % SEQ_SPACE, 1'b0);
            else
               it = make_ack($urandom_range(0, SEQ_SPACE - 1), 1'b0);
         end else if (pick < 85) begin
            if (outstanding > 0 || sent_once[win_base[GEN_VIEW]])
               it = timer_expiry();
            else
               it = new_message(rand_word(), rand_word(), HI_W'(rand_word()));
         end else if (pick < 91) begin
            it = make_ack($urandom_range(0, SEQ_SPACE - 1), 1'b1);
         end else if (pick < 97) begin
            if ($urandom_range(0, 1))
               it = make_ack(int'($signed(16'($urandom))), 1'b0);
            else
               it = make_ack($urandom_range(SEQ_SPACE, SEQ_SPACE + 3), 1'b0);
         end else begin
            it = timer_expiry();
            it.func = FUNC_NONE;
         end
         queue_event(it);
         if (it.func != FUNC_NONE) made++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // drain: everything accepted, every response back, then a short tail
      @(negedge clock);
      while (queued_events.size() != 0 || req_valid) @(negedge clock);
      while (due_responses.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Driver: offer queued beats with random gaps, record expectations on accept
   req_item_type offered;
   int        tx_gap = 0;
   int        tx_beats = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (offered.func != FUNC_NONE)
               due_responses.push_back(window_outcome(CHK_VIEW, offered));
            tx_beats++;
            tx_gap = (tx_beats % 256 < 48) ? 0 : pick_gap();
         end
         if (!req_valid || req_ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (queued_events.size() != 0) begin
               offered = queued_events.pop_front();
               req_func        <= offered.func;
               req_payload_lo  <= offered.lo;
               req_payload_mid <= offered.mid;
               req_payload_hi  <= offered.hi;
               req_rx_seq      <= offered.rx_seq;
               req_rx_ack      <= offered.rx_ack;
               req_rx_check    <= offered.rx_check;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off to back the block up
   int  rx_stall = 0;
   int  rx_beats = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rx_beats++;
         if (!hold_done && rx_beats >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rx_stall = (rx_beats % 256 >= 128 && rx_beats % 256 < 176) ? 0 : pick_gap();
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // Monitor: compare each response beat with the oldest expectation
   rsp_exp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_responses.size() == 0) begin
            $error("response beat with no expectation pending");
            errors++;
         end else begin
            want = due_responses.pop_front();
            check_field("action", want.action, rsp_action);
            check_field("timer_cmd", want.timer, rsp_timer_cmd);
            check_field("tx_seq", want.seq, rsp_tx_seq);
            check_field("tx_check", want.check, $unsigned(rsp_tx_check));
            check_field("tx_payload_lo", want.lo, rsp_tx_payload_lo);
            check_field("tx_payload_mid", want.mid, rsp_tx_payload_mid);
            check_field("tx_payload_hi", want.hi, rsp_tx_payload_hi);
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule
